// File: hdl/text_scroll_window_engine_unit_assert.svh
// Assertion macros shared by the scroll engine modules.
`ifndef TEXT_SCROLL_WINDOW_ENGINE_UNIT_ASSERT_SVH
`define TEXT_SCROLL_WINDOW_ENGINE_UNIT_ASSERT_SVH

// Condition and consequence in the same cycle.
`define TSW_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequence in the following cycle.
`define TSW_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/tsw_pkg.sv
// Types and constants of the text scroll window engine.
package tsw_pkg;

   localparam int TEXT_DEPTH  = 64;
   localparam int MAX_COLUMNS = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam int AW     = $clog2(TEXT_DEPTH);
   localparam int LEN_W  = $clog2(TEXT_DEPTH + 1);
   localparam int COL_W  = $clog2(MAX_COLUMNS + 1);
   localparam int MAG_W  = (LEN_W > COL_W) ? LEN_W : COL_W;
   localparam int OFS_W  = MAG_W + 1;
   localparam int IDX_W  = OFS_W + 1;
   localparam int QA_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] SPACE_CODE = 8'h20;

   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;
   localparam logic [1:0] KIND_STOP  = 2'd3;

   localparam logic [1:0] CSR_DIGITS      = 2'd0;
   localparam logic [1:0] CSR_STEP_TICKS  = 2'd1;
   localparam logic [1:0] CSR_HOLD_TICKS  = 2'd2;
   localparam logic [1:0] CSR_ENTER_RIGHT = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] code;
   } req_type;

   typedef struct packed {
      logic [3:0] column;
      logic [7:0] glyph_code;
      logic       frame_end;
      logic       running;
   } rsp_type;

   // One frame to render: window start, text length, width, run flag.
   typedef struct packed {
      logic signed [OFS_W-1:0] ofs;
      logic [LEN_W-1:0]        len;
      logic [COL_W-1:0]        ncols;
      logic                    run;
   } tsw_frame_type;

   typedef struct packed {
      logic          en;
      logic [AW-1:0] addr;
      logic [7:0]    data;
   } tsw_wr_type;

   typedef struct packed {
      logic full;
      logic empty;
   } tsw_qstat_type;

endpackage

// File: hdl/tsw_front.sv
// Front end: accepts words, keeps the scroll state and queues frames.
`include "text_scroll_window_engine_unit_assert.svh"
module tsw_front import tsw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_data,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_wdata,
   input  tsw_qstat_type qstat,
   input  logic          back_idle,
   output logic          push_valid,
   output tsw_frame_type push_data,
   output tsw_wr_type    text_wr
);

   logic [4:0]              digits_ff, digits_in;
   logic [15:0]             step_ff, step_in;
   logic [15:0]             hold_ff, hold_in;
   logic                    enter_ff, enter_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic                    pending_ff, pending_in;
   logic signed [OFS_W-1:0] ofs_ff, ofs_in;
   logic [15:0]             elapsed_ff, elapsed_in;
   logic                    holding_ff, holding_in;
   logic                    active_ff, active_in;

   logic                    accept;
   logic [COL_W-1:0]        ncols;
   logic signed [OFS_W-1:0] start_ofs;
   logic signed [OFS_W-1:0] ofs_step;
   logic [15:0]             el_inc;
   logic [15:0]             step_eff;
   logic [LEN_W-1:0]        base;
   logic                    start_active;
   logic                    rearm;

   function automatic logic [COL_W-1:0] cols_in_use(input logic [4:0] d);
      logic [4:0] c;
      c = (d inside {5'd6, 5'd8, 5'd16}) ? d : 5'd8;
      if (32'(c) > MAX_COLUMNS) c = 5'(MAX_COLUMNS);
      return COL_W'(c);
   endfunction

   // Loads overwrite the store, so hold them until the back end has drained.
   assign req_ready = (req_data.kind == KIND_LOAD) ? (qstat.empty && back_idle) : !qstat.full;
   assign accept    = req_valid && req_ready;

   assign ncols        = cols_in_use(digits_ff);
   assign start_ofs    = enter_ff ? (OFS_W'(0) - $signed(OFS_W'(ncols))) : OFS_W'(0);
   assign ofs_step     = ofs_ff + OFS_W'(1);
   assign el_inc       = (elapsed_ff != 16'hFFFF) ? elapsed_ff + 16'd1 : elapsed_ff;
   assign step_eff     = (step_ff != 16'd0) ? step_ff : 16'd1;
   assign base         = pending_ff ? LEN_W'(0) : len_ff;
   assign rearm        = (hold_ff != 16'd0) && !enter_ff;
   assign start_active = (len_ff != LEN_W'(0)) && (enter_ff || (len_ff > LEN_W'(ncols)));

   always_comb begin
      digits_in  = digits_ff;
      step_in    = step_ff;
      hold_in    = hold_ff;
      enter_in   = enter_ff;
      len_in     = len_ff;
      pending_in = pending_ff;
      ofs_in     = ofs_ff;
      elapsed_in = elapsed_ff;
      holding_in = holding_ff;
      active_in  = active_ff;
      push_valid = 1'b0;
      push_data  = '{ofs: ofs_ff, len: len_ff, ncols: ncols, run: active_ff};
      text_wr    = '{en: 1'b0, addr: base[AW-1:0], data: req_data.code};

      if (csr_we) begin
         case (csr_index)
            CSR_DIGITS:      digits_in = csr_wdata[4:0];
            CSR_STEP_TICKS:  step_in   = csr_wdata;
            CSR_HOLD_TICKS:  hold_in   = csr_wdata;
            CSR_ENTER_RIGHT: enter_in  = csr_wdata[0];
            default:         ;
         endcase
      end

      if (accept) begin
         case (req_data.kind)
            KIND_LOAD: begin
               pending_in = 1'b0;
               len_in     = base;
               if (base < LEN_W'(TEXT_DEPTH)) begin
                  text_wr.en = 1'b1;
                  len_in     = base + LEN_W'(1);
               end
               active_in  = 1'b0;
               holding_in = 1'b0;
            end
            KIND_START: begin
               pending_in     = 1'b1;
               ofs_in         = start_ofs;
               elapsed_in     = 16'd0;
               active_in      = start_active;
               holding_in     = rearm && start_active;
               push_valid     = 1'b1;
               push_data.ofs  = start_ofs;
               push_data.run  = start_active;
            end
            KIND_TICK: begin
               if (active_ff) begin
                  if (holding_ff) begin
                     elapsed_in = el_inc;
                     if (el_inc >= hold_ff) begin
                        holding_in = 1'b0;
                        elapsed_in = 16'd0;
                     end
                  end else if (el_inc < step_eff) begin
                     elapsed_in = el_inc;
                  end else begin
                     elapsed_in = 16'd0;
                     ofs_in     = ofs_step;
                     // wrap at the text end and re-arm the hold
                     if (ofs_step >= $signed(OFS_W'(len_ff))) begin
                        ofs_in     = start_ofs;
                        holding_in = rearm;
                     end
                     push_valid    = 1'b1;
                     push_data.ofs = ofs_in;
                  end
               end
            end
            KIND_STOP: begin
               active_in  = 1'b0;
               holding_in = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digits_ff  <= 5'd8;
         step_ff    <= 16'd1;
         hold_ff    <= 16'd0;
         enter_ff   <= 1'b0;
         len_ff     <= '0;
         pending_ff <= 1'b1;
         ofs_ff     <= '0;
         elapsed_ff <= '0;
         holding_ff <= 1'b0;
         active_ff  <= 1'b0;
      end else begin
         digits_ff  <= digits_in;
         step_ff    <= step_in;
         hold_ff    <= hold_in;
         enter_ff   <= enter_in;
         len_ff     <= len_in;
         pending_ff <= pending_in;
         ofs_ff     <= ofs_in;
         elapsed_ff <= elapsed_in;
         holding_ff <= holding_in;
         active_ff  <= active_in;
      end
   end

   `TSW_ASSERT_NOW(a_load_drained, text_wr.en, qstat.empty && back_idle, "load while frames pending")
   `TSW_ASSERT_NOW(a_hold_needs_active, holding_ff, active_ff, "holding while not active")
   `TSW_ASSERT_NEXT(a_idle_tick,
                    accept && req_data.kind == KIND_TICK && !active_ff && !csr_we,
                    $stable(elapsed_ff) && $stable(ofs_ff), "idle tick changed state")

endmodule

// File: hdl/tsw_queue.sv
// Short frame command queue between front and back end.
module tsw_queue import tsw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  tsw_frame_type push_data,
   input  logic          pop,
   output logic          pop_valid,
   output tsw_frame_type pop_data,
   output tsw_qstat_type qstat
);

   tsw_frame_type   slot_ff [QUEUE_DEPTH];
   logic [QA_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QA_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   function automatic logic [QA_W-1:0] ptr_next(input logic [QA_W-1:0] p);
      return (32'(p) == QUEUE_DEPTH - 1) ? QA_W'(0) : p + QA_W'(1);
   endfunction

   assign qstat.full  = (count_ff == QC_W'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == QC_W'(0));
   assign pop_valid   = !qstat.empty;
   assign pop_data    = slot_ff[rd_ptr_ff];
   assign do_push     = push_valid && !qstat.full;
   assign do_pop      = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + QC_W'(1);
      if (do_pop && !do_push) count_in = count_ff - QC_W'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hdl/tsw_back.sv
// Back end: text store and frame renderer, one column word per cycle while rsp_ready holds.
`include "text_scroll_window_engine_unit_assert.svh"
module tsw_back import tsw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  tsw_wr_type    text_wr,
   input  logic          cmd_valid,
   input  tsw_frame_type cmd_data,
   output logic          cmd_pop,
   output logic          back_idle,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data
);

   logic [7:0]              store [TEXT_DEPTH];
   logic [7:0]              mem_q_ff;

   logic                    busy_ff, busy_in;
   tsw_frame_type           cur_ff;
   logic [COL_W-1:0]        col_ff, col_in;

   logic                    rd_v_ff, rd_v_in;
   logic [COL_W-1:0]        rd_col_ff;
   logic                    rd_text_ff;
   logic                    rd_last_ff;
   logic                    rd_run_ff;

   logic                    out_v_ff, out_v_in;
   rsp_type                 out_ff;

   logic                    rd_move;
   logic                    issue;
   logic                    last;
   logic signed [IDX_W-1:0] idx;
   logic                    in_text;

   assign rd_move = rd_v_ff && (!out_v_ff || rsp_ready);
   assign issue   = busy_ff && (!rd_v_ff || rd_move);
   assign last    = (col_ff == cur_ff.ncols - COL_W'(1));
   assign cmd_pop = !busy_ff && cmd_valid;

   assign idx     = IDX_W'(cur_ff.ofs) + $signed(IDX_W'(col_ff));
   assign in_text = !idx[IDX_W-1] && (idx < $signed(IDX_W'(cur_ff.len)));

   assign back_idle = !busy_ff && !rd_v_ff;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      busy_in  = busy_ff;
      col_in   = col_ff;
      rd_v_in  = rd_v_ff;
      out_v_in = out_v_ff;
      if (cmd_pop) begin
         busy_in = 1'b1;
         col_in  = '0;
      end
      if (issue) begin
         col_in = col_ff + COL_W'(1);
         if (last) busy_in = 1'b0;
      end
      if (rd_move) out_v_in = 1'b1;
      else if (rsp_ready) out_v_in = 1'b0;
      if (issue) rd_v_in = 1'b1;
      else if (rd_move) rd_v_in = 1'b0;
   end

   // Store write from the front end; read only advances on issue.
   always_ff @(posedge clock) begin
      if (text_wr.en) store[text_wr.addr] <= text_wr.data;
      if (issue) mem_q_ff <= store[idx[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) cur_ff <= cmd_data;
      if (issue) begin
         rd_col_ff  <= col_ff;
         rd_text_ff <= in_text;
         rd_last_ff <= last;
         rd_run_ff  <= cur_ff.run;
      end
      if (rd_move) begin
         out_ff.column     <= 4'(rd_col_ff);
         out_ff.glyph_code <= rd_text_ff ? mem_q_ff : SPACE_CODE;
         out_ff.frame_end  <= rd_last_ff;
         out_ff.running    <= rd_run_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         col_ff   <= '0;
         rd_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         col_ff   <= col_in;
         rd_v_ff  <= rd_v_in;
         out_v_ff <= out_v_in;
      end
   end

   `TSW_ASSERT_NEXT(a_frame_done, issue && last, !busy_ff, "renderer busy after last column")
   `TSW_ASSERT_NEXT(a_read_hold, rd_v_ff && !rd_move, rd_v_ff && $stable(mem_q_ff), "stalled read data lost")
   `TSW_ASSERT_NOW(a_col_range, issue, col_ff < cur_ff.ncols, "column beyond frame width")

endmodule

// File: hdl/text_scroll_window_engine_unit.sv
// A start or tick word's frame passes the frame queue, the renderer's frame register, the store read register
// and the output register before its first column word leaves; one column word per cycle while rsp_ready holds.
// The renderer takes a new frame only after the last column of the current one is issued. Load words wait until
// the renderer and frame queue have drained; other words wait only while the frame queue is full.
// Reset is synchronous and clears control state; the text store is not cleared.
module text_scroll_window_engine_unit import tsw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   tsw_qstat_type qstat;
   logic          back_idle;
   logic          push_valid;
   tsw_frame_type push_data;
   tsw_wr_type    text_wr;
   logic          cmd_pop;
   logic          cmd_valid;
   tsw_frame_type cmd_data;

   tsw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .qstat      (qstat),
      .back_idle  (back_idle),
      .push_valid (push_valid),
      .push_data  (push_data),
      .text_wr    (text_wr)
   );

   tsw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (cmd_pop),
      .pop_valid  (cmd_valid),
      .pop_data   (cmd_data),
      .qstat      (qstat)
   );

   tsw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .text_wr   (text_wr),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .back_idle (back_idle),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
